// ===== rtl/bpc_pkg.sv =====
// Shared types, register indexes and constants for the pressure compensation block.
package bpc_pkg;

    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 48;

    localparam logic [CfgAddrW-1:0] REG_CAL_A_FIRST = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_CAL_A_LAST  = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_CAL_B       = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_CAL_M       = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_OSS         = 3'd4;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    // Datapath micro-operations.
    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_T_X1,
        UOP_T_DEN,
        UOP_T_NUM,
        UOP_DIV_START,
        UOP_DIV_STEP,
        UOP_T_B5,
        UOP_P_B6,
        UOP_P_SQ,
        UOP_P_X1A,
        UOP_P_X2A,
        UOP_P_B3,
        UOP_P_X1B,
        UOP_P_X2B,
        UOP_P_X3,
        UOP_P_B4,
        UOP_P_B7,
        UOP_P_DIVSEL,
        UOP_P_QPOST,
        UOP_P_T1,
        UOP_P_T2,
        UOP_P_T3,
        UOP_P_T4,
        UOP_P_FIN
    } uop_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_T_X1,
        ST_T_DEN,
        ST_T_NUM,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_T_B5,
        ST_P_B6,
        ST_P_SQ,
        ST_P_X1A,
        ST_P_X2A,
        ST_P_B3,
        ST_P_X1B,
        ST_P_X2B,
        ST_P_X3,
        ST_P_B4,
        ST_P_B7,
        ST_P_DIVSEL,
        ST_P_QPOST,
        ST_P_T1,
        ST_P_T2,
        ST_P_T3,
        ST_P_T4,
        ST_P_FIN,
        ST_OUT
    } state_t;

    typedef struct packed {
        uop_t uop;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_press;
        logic div_zero;
        logic div_done;
    } status_t;

    localparam logic [31:0] C4000   = 32'd4000;
    localparam logic [31:0] C32768  = 32'd32768;
    localparam logic [31:0] C50000  = 32'd50000;
    localparam logic [31:0] CMSB    = 32'h8000_0000;
    localparam logic [31:0] C3038   = 32'd3038;
    localparam logic [31:0] CM7357  = 32'hFFFF_E343;
    localparam logic [31:0] C3791   = 32'd3791;

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        asr = 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] w);
        sx16 = {{16{w[15]}}, w};
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        mul32 = a * b;
    endfunction

endpackage

// ===== rtl/bpc_ctrl.sv =====
// Sequencer for the temperature and pressure compensation steps.
module bpc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic                 out_free,
    input  bpc_pkg::status_t     status,
    output logic                 busy,
    output bpc_pkg::cmd_t        cmd
);

    bpc_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.uop      = bpc_pkg::UOP_NONE;
        cmd.out_load = 1'b0;
        busy         = 1'b1;
        unique case (state_reg)
            bpc_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (in_fire) begin
                    cmd.uop    = bpc_pkg::UOP_LOAD;
                    state_next = bpc_pkg::ST_LOAD;
                end
            end
            bpc_pkg::ST_LOAD: begin
                state_next = status.is_press ? bpc_pkg::ST_P_B6 : bpc_pkg::ST_T_X1;
            end
            bpc_pkg::ST_T_X1: begin
                cmd.uop = bpc_pkg::UOP_T_X1; state_next = bpc_pkg::ST_T_DEN;
            end
            bpc_pkg::ST_T_DEN: begin
                cmd.uop = bpc_pkg::UOP_T_DEN; state_next = bpc_pkg::ST_T_NUM;
            end
            bpc_pkg::ST_T_NUM: begin
                cmd.uop = bpc_pkg::UOP_T_NUM; state_next = bpc_pkg::ST_DIV_START;
            end
            bpc_pkg::ST_DIV_START: begin
                if (status.div_zero) begin
                    state_next = bpc_pkg::ST_OUT;
                end else begin
                    cmd.uop = bpc_pkg::UOP_DIV_START; state_next = bpc_pkg::ST_DIV_RUN;
                end
            end
            bpc_pkg::ST_DIV_RUN: begin
                cmd.uop = bpc_pkg::UOP_DIV_STEP;
                if (status.div_done) begin
                    state_next = status.is_press ? bpc_pkg::ST_P_QPOST : bpc_pkg::ST_T_B5;
                end
            end
            bpc_pkg::ST_T_B5: begin
                cmd.uop = bpc_pkg::UOP_T_B5; state_next = bpc_pkg::ST_OUT;
            end
            bpc_pkg::ST_P_B6: begin
                cmd.uop = bpc_pkg::UOP_P_B6; state_next = bpc_pkg::ST_P_SQ;
            end
            bpc_pkg::ST_P_SQ: begin
                cmd.uop = bpc_pkg::UOP_P_SQ; state_next = bpc_pkg::ST_P_X1A;
            end
            bpc_pkg::ST_P_X1A: begin
                cmd.uop = bpc_pkg::UOP_P_X1A; state_next = bpc_pkg::ST_P_X2A;
            end
            bpc_pkg::ST_P_X2A: begin
                cmd.uop = bpc_pkg::UOP_P_X2A; state_next = bpc_pkg::ST_P_B3;
            end
            bpc_pkg::ST_P_B3: begin
                cmd.uop = bpc_pkg::UOP_P_B3; state_next = bpc_pkg::ST_P_X1B;
            end
            bpc_pkg::ST_P_X1B: begin
                cmd.uop = bpc_pkg::UOP_P_X1B; state_next = bpc_pkg::ST_P_X2B;
            end
            bpc_pkg::ST_P_X2B: begin
                cmd.uop = bpc_pkg::UOP_P_X2B; state_next = bpc_pkg::ST_P_X3;
            end
            bpc_pkg::ST_P_X3: begin
                cmd.uop = bpc_pkg::UOP_P_X3; state_next = bpc_pkg::ST_P_B4;
            end
            bpc_pkg::ST_P_B4: begin
                cmd.uop = bpc_pkg::UOP_P_B4; state_next = bpc_pkg::ST_P_B7;
            end
            bpc_pkg::ST_P_B7: begin
                cmd.uop = bpc_pkg::UOP_P_B7; state_next = bpc_pkg::ST_P_DIVSEL;
            end
            bpc_pkg::ST_P_DIVSEL: begin
                cmd.uop = bpc_pkg::UOP_P_DIVSEL; state_next = bpc_pkg::ST_DIV_START;
            end
            bpc_pkg::ST_P_QPOST: begin
                cmd.uop = bpc_pkg::UOP_P_QPOST; state_next = bpc_pkg::ST_P_T1;
            end
            bpc_pkg::ST_P_T1: begin
                cmd.uop = bpc_pkg::UOP_P_T1; state_next = bpc_pkg::ST_P_T2;
            end
            bpc_pkg::ST_P_T2: begin
                cmd.uop = bpc_pkg::UOP_P_T2; state_next = bpc_pkg::ST_P_T3;
            end
            bpc_pkg::ST_P_T3: begin
                cmd.uop = bpc_pkg::UOP_P_T3; state_next = bpc_pkg::ST_P_T4;
            end
            bpc_pkg::ST_P_T4: begin
                cmd.uop = bpc_pkg::UOP_P_T4; state_next = bpc_pkg::ST_P_FIN;
            end
            bpc_pkg::ST_P_FIN: begin
                cmd.uop = bpc_pkg::UOP_P_FIN; state_next = bpc_pkg::ST_OUT;
            end
            bpc_pkg::ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = bpc_pkg::ST_IDLE;
                end
            end
            default: state_next = bpc_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/bpc_datapath.sv =====
// Registers, multiplier, shifter and serial divider of the compensation math.
module bpc_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bpc_pkg::cmd_t                cmd,
    input  logic                         in_op,
    input  logic [18:0]                  in_raw,
    input  logic [47:0]                  cal_a1_reg,
    input  logic [47:0]                  cal_a2_reg,
    input  logic [31:0]                  cal_b_reg,
    input  logic [31:0]                  cal_m_reg,
    input  logic [1:0]                   oss_reg,
    output bpc_pkg::status_t             status,
    output logic                         res_kind_reg,
    output logic [18:0]                  res_value_reg,
    output logic                         res_err_reg
);

    logic        op_reg;
    logic [31:0] raw_reg;
    logic [31:0] b5_reg, b5_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, p_reg, sq_reg, b6_reg;
    logic [31:0] num_reg, den_reg, rem_reg, quo_reg;
    logic        nneg_reg, qneg_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [32:0] trial;
    logic [31:0] rem_sh;
    logic [31:0] tmp;
    logic signed [31:0] sv;

    assign ac1 = bpc_pkg::sx16(cal_a1_reg[15:0]);
    assign ac2 = bpc_pkg::sx16(cal_a1_reg[31:16]);
    assign ac3 = bpc_pkg::sx16(cal_a1_reg[47:32]);
    assign ac4 = {16'd0, cal_a2_reg[15:0]};
    assign ac5 = {16'd0, cal_a2_reg[31:16]};
    assign ac6 = {16'd0, cal_a2_reg[47:32]};
    assign b1  = bpc_pkg::sx16(cal_b_reg[15:0]);
    assign b2  = bpc_pkg::sx16(cal_b_reg[31:16]);
    assign mc  = bpc_pkg::sx16(cal_m_reg[15:0]);
    assign md  = bpc_pkg::sx16(cal_m_reg[31:16]);

    assign rem_sh = {rem_reg[30:0], num_reg[31]};
    assign trial  = {1'b0, rem_sh} - {1'b0, den_reg};

    assign status.is_press = op_reg;
    assign status.div_zero = (den_reg == 32'd0);
    assign status.div_done = (cnt_reg == 6'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b5_reg <= '0;
        end else begin
            b5_reg <= b5_next;
        end
    end

    always_comb begin
        b5_next = b5_reg;
        if (cmd.uop == bpc_pkg::UOP_T_B5) begin
            b5_next = a_reg + (qneg_reg ? 32'(-quo_reg) : quo_reg);
        end
    end

    always_comb begin
        sv = $signed(p_reg);
        if (sv > 32'sd262143) begin
            tmp = 32'd262143;
        end else if (sv < -32'sd262144) begin
            tmp = 32'hFFFC_0000;
        end else begin
            tmp = p_reg;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.uop)
            bpc_pkg::UOP_LOAD: begin
                op_reg  <= in_op;
                raw_reg <= {13'd0, in_raw};
                p_reg   <= '0;
                den_reg <= 32'd1;
            end
            bpc_pkg::UOP_T_X1: a_reg <= bpc_pkg::mul32(raw_reg - ac6, ac5);
            bpc_pkg::UOP_T_DEN: begin
                a_reg <= bpc_pkg::asr(a_reg, 5'd15);
                d_reg <= bpc_pkg::asr(a_reg, 5'd15) + md;
            end
            bpc_pkg::UOP_T_NUM: begin
                num_reg  <= mc[31] ? 32'(-(mc << 11)) : (mc << 11);
                nneg_reg <= mc[31];
                den_reg  <= d_reg[31] ? 32'(-d_reg) : d_reg;
                qneg_reg <= mc[31] ^ d_reg[31];
            end
            bpc_pkg::UOP_DIV_START: begin
                rem_reg <= '0;
                quo_reg <= '0;
                cnt_reg <= 6'd32;
            end
            bpc_pkg::UOP_DIV_STEP: begin
                if (cnt_reg != 6'd0) begin
                    num_reg <= {num_reg[30:0], 1'b0};
                    if (!trial[32]) begin
                        rem_reg <= trial[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
            bpc_pkg::UOP_T_B5: p_reg <= bpc_pkg::asr(b5_next + 32'd8, 5'd4);
            bpc_pkg::UOP_P_B6: b6_reg <= b5_reg - bpc_pkg::C4000;
            bpc_pkg::UOP_P_SQ: a_reg <= bpc_pkg::mul32(b6_reg, b6_reg);
            bpc_pkg::UOP_P_X1A: begin
                sq_reg <= bpc_pkg::asr(a_reg, 5'd12);
                b_reg  <= bpc_pkg::mul32(ac2, b6_reg);
            end
            bpc_pkg::UOP_P_X2A: c_reg <= bpc_pkg::mul32(b2, sq_reg);
            bpc_pkg::UOP_P_B3: begin
                a_reg <= bpc_pkg::asr(((ac1 * 32'd4 + bpc_pkg::asr(c_reg, 5'd11)
                         + bpc_pkg::asr(b_reg, 5'd11)) << oss_reg) + 32'd2, 5'd2);
                b_reg <= bpc_pkg::mul32(ac3, b6_reg);
            end
            bpc_pkg::UOP_P_X1B: c_reg <= bpc_pkg::mul32(b1, sq_reg);
            bpc_pkg::UOP_P_X2B: d_reg <= bpc_pkg::asr(b_reg, 5'd13)
                                         + bpc_pkg::asr(c_reg, 5'd16) + 32'd2;
            bpc_pkg::UOP_P_X3: d_reg <= bpc_pkg::asr(d_reg, 5'd2) + bpc_pkg::C32768;
            bpc_pkg::UOP_P_B4: d_reg <= bpc_pkg::mul32(ac4, d_reg) >> 15;
            bpc_pkg::UOP_P_B7: b_reg <= bpc_pkg::mul32(raw_reg - a_reg,
                                         bpc_pkg::C50000 >> oss_reg);
            bpc_pkg::UOP_P_DIVSEL: begin
                den_reg  <= d_reg;
                nneg_reg <= (b_reg >= bpc_pkg::CMSB);
                num_reg  <= (b_reg >= bpc_pkg::CMSB) ? b_reg : (b_reg << 1);
                qneg_reg <= 1'b0;
            end
            bpc_pkg::UOP_P_QPOST: p_reg <= nneg_reg ? (quo_reg << 1) : quo_reg;
            bpc_pkg::UOP_P_T1: begin
                a_reg <= bpc_pkg::asr(p_reg, 5'd8);
                b_reg <= bpc_pkg::mul32(p_reg, bpc_pkg::CM7357);
            end
            bpc_pkg::UOP_P_T2: a_reg <= bpc_pkg::mul32(a_reg, a_reg);
            bpc_pkg::UOP_P_T3: a_reg <= bpc_pkg::mul32(a_reg, bpc_pkg::C3038);
            bpc_pkg::UOP_P_T4: a_reg <= bpc_pkg::asr(a_reg, 5'd16)
                                        + bpc_pkg::asr(b_reg, 5'd16) + bpc_pkg::C3791;
            bpc_pkg::UOP_P_FIN: p_reg <= p_reg + bpc_pkg::asr(a_reg, 5'd4);
            default: ;
        endcase
        if (cmd.out_load) begin
            res_kind_reg  <= op_reg;
            res_err_reg   <= (den_reg == 32'd0);
            res_value_reg <= (den_reg == 32'd0) ? 19'd0 : tmp[18:0];
        end
    end

endmodule

// ===== rtl/barometric_pressure_compensation.sv =====
// Top level: stream ports, calibration registers, sequencer and datapath.
// One item in flight at a time: each item runs through a serial divider and a
// chain of single-multiplier steps; a zero divisor skips the divider. The
// result sits in an output register, a stalled result holds the sequencer, and
// the next item is taken in the cycle after the result is loaded.
module barometric_pressure_compensation (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // raw_reading[18:0]
    input  logic                          s_tuser,   // opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // compensated_value[18:0], divide_error
    output logic                          m_tuser,   // result_kind
    input  logic                          cfg_we,
    input  logic [bpc_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [bpc_pkg::CfgDataW-1:0]  cfg_wdata
);

    logic [47:0] cal_a1_reg, cal_a2_reg;
    logic [31:0] cal_b_reg, cal_m_reg;
    logic [1:0]  oss_reg;
    logic        m_tvalid_reg;
    logic        busy, in_fire, out_free;
    logic        res_kind, res_err;
    logic [18:0] res_value;
    bpc_pkg::cmd_t    cmd;
    bpc_pkg::status_t status;

    assign s_tready = !busy;
    assign in_fire  = s_tvalid && !busy;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_a1_reg <= '0;
            cal_a2_reg <= '0;
            cal_b_reg  <= '0;
            cal_m_reg  <= '0;
            oss_reg    <= 2'd3;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                bpc_pkg::REG_CAL_A_FIRST: cal_a1_reg <= cfg_wdata;
                bpc_pkg::REG_CAL_A_LAST:  cal_a2_reg <= cfg_wdata;
                bpc_pkg::REG_CAL_B:       cal_b_reg  <= cfg_wdata[31:0];
                bpc_pkg::REG_CAL_M:       cal_m_reg  <= cfg_wdata[31:0];
                bpc_pkg::REG_OSS:         oss_reg    <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    bpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_free (out_free),
        .status   (status),
        .busy     (busy),
        .cmd      (cmd)
    );

    bpc_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_op         (s_tuser),
        .in_raw        (s_tdata[18:0]),
        .cal_a1_reg    (cal_a1_reg),
        .cal_a2_reg    (cal_a2_reg),
        .cal_b_reg     (cal_b_reg),
        .cal_m_reg     (cal_m_reg),
        .oss_reg       (oss_reg),
        .status        (status),
        .res_kind_reg  (res_kind),
        .res_value_reg (res_value),
        .res_err_reg   (res_err)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, res_err, res_value};
    assign m_tuser  = res_kind;

endmodule

// ===== dv/tb.sv =====
// Testbench for the barometric pressure compensation block: directed and random items
// checked against a built-in compensation predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        kind;
        logic [18:0] value;
        logic        div_err;
    } comp_result_t;

    class comp_scoreboard;
        logic [47:0] cal_a_first;
        logic [47:0] cal_a_last;
        logic [31:0] cal_b;
        logic [31:0] cal_m;
        logic [1:0]  oss;
        logic [31:0] b5_term;
        comp_result_t pending[$];
        int errors;

        function new();
            cal_a_first = '0;
            cal_a_last = '0;
            cal_b = '0;
            cal_m = '0;
            oss = 2'd3;
            b5_term = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [bpc_pkg::CfgAddrW-1:0] idx, logic [47:0] val);
            case (idx)
                bpc_pkg::REG_CAL_A_FIRST: cal_a_first = val;
                bpc_pkg::REG_CAL_A_LAST:  cal_a_last = val;
                bpc_pkg::REG_CAL_B:       cal_b = val[31:0];
                bpc_pkg::REG_CAL_M:       cal_m = val[31:0];
                bpc_pkg::REG_OSS:         oss = val[1:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] sra(logic [31:0] v, int s);
            return 32'($signed(v) >>> s);
        endfunction

        function logic [31:0] sgn16(logic [15:0] w);
            return {{16{w[15]}}, w};
        endfunction

        function logic [18:0] clamp(logic [31:0] v);
            if ($signed(v) > 262143) return 19'h3FFFF;
            if ($signed(v) < -262144) return 19'h40000;
            return v[18:0];
        endfunction

        function void note_item(logic op, logic [18:0] raw);
            comp_result_t r;
            logic [31:0] rw, x1, x2, x3, den, q, b6, sq, b3, b4, b7, p;
            logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
            rw = {13'd0, raw};
            r.kind = op;
            r.value = '0;
            r.div_err = 1'b0;
            ac1 = sgn16(cal_a_first[15:0]);
            ac2 = sgn16(cal_a_first[31:16]);
            ac3 = sgn16(cal_a_first[47:32]);
            ac4 = {16'd0, cal_a_last[15:0]};
            ac5 = {16'd0, cal_a_last[31:16]};
            ac6 = {16'd0, cal_a_last[47:32]};
            b1 = sgn16(cal_b[15:0]);
            b2 = sgn16(cal_b[31:16]);
            mc = sgn16(cal_m[15:0]);
            md = sgn16(cal_m[31:16]);
            if (op == bpc_pkg::OP_TEMP) begin
                x1 = sra((rw - ac6) * ac5, 15);
                den = x1 + md;
                if (den == 0) begin
                    r.div_err = 1'b1;
                end else begin
                    q = 32'($signed(mc * 32'd2048) / $signed(den));
                    b5_term = x1 + q;
                    r.value = clamp(sra(b5_term + 32'd8, 4));
                end
            end else begin
                b6 = b5_term - bpc_pkg::C4000;
                sq = sra(b6 * b6, 12);
                x1 = sra(b2 * sq, 11);
                x2 = sra(ac2 * b6, 11);
                x3 = x1 + x2;
                b3 = sra(((ac1 * 32'd4 + x3) << oss) + 32'd2, 2);
                x1 = sra(ac3 * b6, 13);
                x2 = sra(b1 * sq, 16);
                x3 = sra(x1 + x2 + 32'd2, 2);
                b4 = (ac4 * (x3 + bpc_pkg::C32768)) >> 15;
                b7 = (rw - b3) * (bpc_pkg::C50000 >> oss);
                if (b4 == 0) begin
                    r.div_err = 1'b1;
                end else begin
                    if (b7 < bpc_pkg::CMSB) p = (b7 << 1) / b4;
                    else p = (b7 / b4) << 1;
                    x1 = sra(p, 8);
                    x1 = x1 * x1;
                    x1 = sra(x1 * bpc_pkg::C3038, 16);
                    x2 = sra(p * bpc_pkg::CM7357, 16);
                    p = p + sra(x1 + x2 + bpc_pkg::C3791, 4);
                    r.value = clamp(p);
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(comp_result_t got);
            comp_result_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result kind=%0d value=%h err=%0d",
                         $realtime, got.kind, got.value, got.div_err);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.kind !== exp_r.kind) begin
                $display("%0t: kind expected %0d actual %0d", $realtime, exp_r.kind, got.kind);
                errors++;
            end
            if (got.value !== exp_r.value) begin
                $display("%0t: value expected %h actual %h", $realtime, exp_r.value, got.value);
                errors++;
            end
            if (got.div_err !== exp_r.div_err) begin
                $display("%0t: divide_error expected %0d actual %0d",
                         $realtime, exp_r.div_err, got.div_err);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [bpc_pkg::CfgAddrW-1:0] cfg_addr;
    logic [bpc_pkg::CfgDataW-1:0] cfg_wdata;

    comp_scoreboard sb;
    int cycles = 0;
    bit rx_on;
    bit no_gaps;

    barometric_pressure_compensation u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        aresetn = 1'b0;
        sb = new();
        rx_on = 1'b0;
        no_gaps = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Result side: random stall per item, check at handshake.
    always begin
        int wait_n;
        @(posedge aclk);
        if (rx_on) begin
            wait_n = no_gaps ? 0 : $urandom_range(0, 16);
            repeat (wait_n) @(posedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            sb.check_result({m_tuser, m_tdata[18:0], m_tdata[19]});
            m_tready <= 1'b0;
        end
    end

    task automatic write_cfg(logic [bpc_pkg::CfgAddrW-1:0] idx, logic [47:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_item(logic op, logic [18:0] raw);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'd0, raw};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sb.note_item(op, raw);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (80) @(posedge aclk);
    endtask

    task automatic load_cal(bit datasheet);
        if (datasheet) begin
            // AC3 -14383 AC2 -72 AC1 408
            write_cfg(bpc_pkg::REG_CAL_A_FIRST, {16'hC7D1, 16'hFFB8, 16'h0198});
            write_cfg(bpc_pkg::REG_CAL_A_LAST, {16'd23153, 16'd32757, 16'd32741});
            write_cfg(bpc_pkg::REG_CAL_B, 48'({16'd4, 16'd6190}));
            write_cfg(bpc_pkg::REG_CAL_M, 48'({16'd2868, 16'hDDF9})); // MD 2868 MC -8711
        end else begin
            write_cfg(bpc_pkg::REG_CAL_A_FIRST, 48'({$urandom, $urandom}));
            write_cfg(bpc_pkg::REG_CAL_A_LAST, 48'({$urandom, $urandom}));
            write_cfg(bpc_pkg::REG_CAL_B, 48'($urandom));
            write_cfg(bpc_pkg::REG_CAL_M, 48'($urandom));
        end
    endtask

    initial begin
        logic [18:0] raw;
        int phase;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        rx_on = 1'b1;

        // Pressure before any temperature, all calibration zero: divisor zero.
        send_item(bpc_pkg::OP_PRESS, 19'd23843);
        send_item(bpc_pkg::OP_TEMP, 19'd27898);
        drain();

        load_cal(1'b1);
        send_item(bpc_pkg::OP_TEMP, 19'd27898);
        send_item(bpc_pkg::OP_PRESS, 19'd23843);
        send_item(bpc_pkg::OP_TEMP, 19'd0);
        send_item(bpc_pkg::OP_PRESS, 19'h7FFFF);
        send_item(bpc_pkg::OP_TEMP, 19'h7FFFF);
        send_item(bpc_pkg::OP_PRESS, 19'd0);
        drain();
        // Zero temperature divisor: AC5 = 0 makes X1 = 0, MD = 0.
        write_cfg(bpc_pkg::REG_CAL_M, 48'({16'd0, 16'h8000}));
        write_cfg(bpc_pkg::REG_CAL_A_LAST, {16'hFFFF, 16'd0, 16'hFFFF});
        send_item(bpc_pkg::OP_TEMP, 19'd1234);
        send_item(bpc_pkg::OP_PRESS, 19'd40000);
        drain();
        // Extreme calibrations to hit saturation, invalid register index.
        write_cfg(bpc_pkg::REG_CAL_A_FIRST, 48'h8000_7FFF_8000);
        write_cfg(bpc_pkg::REG_CAL_A_LAST, 48'hFFFF_FFFF_0001);
        write_cfg(bpc_pkg::REG_CAL_B, 48'h7FFF_8000);
        write_cfg(bpc_pkg::REG_CAL_M, 48'h0001_7FFF);
        write_cfg(3'd7, 48'hFFFF_FFFF_FFFF);
        for (int k = 0; k < 4; k++) begin
            write_cfg(bpc_pkg::REG_OSS, 48'(k));
            send_item(bpc_pkg::OP_TEMP, 19'(19'h5A5A5 ^ k));
            send_item(bpc_pkg::OP_PRESS, 19'(19'h2A5A5 + k));
            drain();
        end

        // Random phases over calibration sets and oversampling settings.
        for (phase = 0; phase < 20; phase++) begin
            no_gaps = (phase % 5 == 3);
            load_cal(phase % 2 == 0);
            write_cfg(bpc_pkg::REG_OSS, 48'($urandom_range(0, 3)));
            for (int i = 0; i < 100; i++) begin
                raw = ($urandom_range(0, 3) == 0) ? 19'($urandom)
                                                  : 19'($urandom_range(15000, 40000));
                send_item($urandom_range(0, 2) == 0 ? bpc_pkg::OP_TEMP : bpc_pkg::OP_PRESS,
                          raw);
            end
            drain();
        end
        no_gaps = 1'b0;

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/bpc_pkg.sv
rtl/bpc_ctrl.sv
rtl/bpc_datapath.sv
rtl/barometric_pressure_compensation.sv
dv/tb.sv
